@@ sv/dlts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dlts_pkg
// Shared types and constants of the delta-list task scheduler.
// ----------------------------------------------------------------------------
package dlts_pkg;

    localparam int MAX_TASKS     = 16;
    localparam int MS_PER_SECOND = 1000;

    localparam logic [15:0] TPS_RESET = 16'd1000;

    // n / 1000 for 32-bit n: (n * ceil(2^38 / 1000)) >> 38
    localparam int          DIV_SHIFT = 38;
    localparam int          DIV_MUL_W = 29;
    localparam longint      DIV_MUL_L =
        ((64'd1 << DIV_SHIFT) + MS_PER_SECOND - 1) / MS_PER_SECOND;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_L[DIV_MUL_W-1:0];
    localparam int          PROD_W    = 32;
    localparam int          SCALED_W  = PROD_W + DIV_MUL_W;
    localparam int          QUOT_W    = SCALED_W - DIV_SHIFT;

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_DISPATCH = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  task_id;
        logic [15:0] delay_ms;
        logic [15:0] period_ms;
    } in_req_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] run_task;
    } out_req_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  task_id;
        logic [15:0] delta;
        logic [15:0] period;
    } cell_data_t;

    typedef struct packed {
        logic pop;
        logic tick;
    } cell_ctrl_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] ticks;
    } tok_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CONV,
        S_WALK,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

@@ sv/dlts_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dlts_cell
// One list entry: holds task, delta and period, compares the passing
// insertion token, shifts right on insert or left on pop, decrements on tick.
// ----------------------------------------------------------------------------
module dlts_cell
    import dlts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] new_task,
    input  logic [15:0] new_period,
    input  cell_data_t left_data,
    input  logic       shift_in,
    input  tok_t       tok_in,
    input  cell_data_t right_data,
    output cell_data_t data,
    output cell_data_t pass_data,
    output logic       shift_out,
    output tok_t       tok_out
);

    logic        valid_reg,  valid_next;
    logic [7:0]  task_reg,   task_next;
    logic [15:0] delta_reg,  delta_next;
    logic [15:0] period_reg, period_next;
    logic        tok_valid_reg, tok_valid_next;
    logic [15:0] tok_ticks_reg, tok_ticks_next;
    logic        ins_here;

    assign ins_here = tok_in.valid && (!valid_reg || (tok_in.ticks < delta_reg));

    assign data      = '{valid: valid_reg, task_id: task_reg,
                         delta: delta_reg, period: period_reg};
    assign shift_out = ins_here || shift_in;
    assign tok_out   = '{valid: tok_valid_reg, ticks: tok_ticks_reg};

    always_comb
    begin
        pass_data = data;
        if (ins_here)
        begin
            pass_data.delta = delta_reg - tok_in.ticks;
        end
    end

    always_comb
    begin
        valid_next     = valid_reg;
        task_next      = task_reg;
        delta_next     = delta_reg;
        period_next    = period_reg;
        tok_valid_next = tok_in.valid && !ins_here;
        tok_ticks_next = tok_in.ticks - delta_reg;
        if (ctrl.pop)
        begin
            valid_next  = right_data.valid;
            task_next   = right_data.task_id;
            delta_next  = right_data.delta;
            period_next = right_data.period;
        end
        else if (ins_here)
        begin
            valid_next  = 1'b1;
            task_next   = new_task;
            delta_next  = tok_in.ticks;
            period_next = new_period;
        end
        else if (shift_in)
        begin
            valid_next  = left_data.valid;
            task_next   = left_data.task_id;
            delta_next  = left_data.delta;
            period_next = left_data.period;
        end
        else if (ctrl.tick && valid_reg && (delta_reg != 16'd0))
        begin
            delta_next = delta_reg - 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg      <= task_next;
        delta_reg     <= delta_next;
        period_reg    <= period_next;
        tok_ticks_reg <= tok_ticks_next;
    end

endmodule
`default_nettype wire

@@ sv/dlts_conv.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dlts_conv
// Milliseconds to ticks: ms * ticks_per_second / 1000, saturated to 16 bits.
// Two multiply stages; done is start passed through v1_reg and v2_reg.
// ----------------------------------------------------------------------------
module dlts_conv
    import dlts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] ms,
    input  logic [15:0] tps,
    output logic [15:0] ticks,
    output logic        done
);

    logic                v1_reg,     v1_next;
    logic                v2_reg,     v2_next;
    logic [PROD_W-1:0]   prod_reg,   prod_next;
    logic [SCALED_W-1:0] scaled_reg, scaled_next;
    logic [QUOT_W-1:0]   quot;

    assign v1_next     = start;
    assign v2_next     = v1_reg;
    assign prod_next   = PROD_W'(ms) * PROD_W'(tps);
    assign scaled_next = SCALED_W'(prod_reg) * SCALED_W'(DIV_MUL);

    assign quot  = scaled_reg[SCALED_W-1:DIV_SHIFT];
    assign ticks = (quot[QUOT_W-1:16] != '0) ? 16'hFFFF : quot[15:0];
    assign done  = v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        scaled_reg <= scaled_next;
    end

endmodule
`default_nettype wire

@@ sv/delta_list_task_scheduler_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// delta_list_task_scheduler_core
// Timer task list kept as a row of cells ordered by due time, each holding
// its tick delta from the entry before it.
// ----------------------------------------------------------------------------
//  channel | signals                          | accepted when
//  --------+----------------------------------+----------------------------
//  in      | in_valid, in_stall, in_data      | in_valid && !in_stall
//  out     | out_valid, out_stall, out_data   | out_valid && !out_stall
//  cfg     | cfg_we, cfg_wdata                | cfg_we
//
//  One request at a time. Tick, dispatch without re-add, op 3 and a refused
//  add go through S_EXEC and S_DONE. An add, or a dispatch with a re-add,
//  goes through S_EXEC, S_CONV, S_WALK and S_DONE, the insertion token
//  travelling one cell a cycle to cell position k (0..MAX_TASKS-1); S_WALK
//  is skipped for k = 0. A finished result waits in the output register
//  while the next request is taken. No clearing pass after reset.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler_core
    import dlts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_req_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_req_t    out_data
);

    state_t      state_reg, state_next;
    logic [15:0] tps_reg;
    in_req_t     req_reg,   req_next;
    out_req_t    res_reg,   res_next;
    logic        out_valid_reg, out_valid_next;
    out_req_t    out_data_reg,  out_data_next;

    logic        pop;
    logic        tick;
    logic        conv_start;
    logic [15:0] conv_ms;
    logic [15:0] conv_ticks;
    logic        conv_done;
    tok_t        tok0;
    logic        list_full;
    logic        head_due;
    logic        out_load;

    cell_data_t  cell_q    [MAX_TASKS];
    cell_data_t  cell_pass [MAX_TASKS];
    logic        cell_shift[MAX_TASKS];
    tok_t        cell_tok  [MAX_TASKS];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++)
        begin : g_cell
            cell_ctrl_t ctrl;
            cell_data_t left_d;
            cell_data_t right_d;
            logic       sh_in;
            tok_t       t_in;

            if (gi == 0)
            begin : g_first
                assign ctrl   = '{pop: pop, tick: tick};
                assign left_d = '0;
                assign sh_in  = 1'b0;
                assign t_in   = tok0;
            end
            else
            begin : g_rest
                assign ctrl   = '{pop: pop, tick: 1'b0};
                assign left_d = cell_pass[gi-1];
                assign sh_in  = cell_shift[gi-1];
                assign t_in   = cell_tok[gi-1];
            end

            if (gi == MAX_TASKS - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_inner
                assign right_d = cell_q[gi+1];
            end

            dlts_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_task   (req_reg.task_id),
                .new_period (req_reg.period_ms),
                .left_data  (left_d),
                .shift_in   (sh_in),
                .tok_in     (t_in),
                .right_data (right_d),
                .data       (cell_q[gi]),
                .pass_data  (cell_pass[gi]),
                .shift_out  (cell_shift[gi]),
                .tok_out    (cell_tok[gi])
            );
        end
    endgenerate

    dlts_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .ms    (conv_ms),
        .tps   (tps_reg),
        .ticks (conv_ticks),
        .done  (conv_done)
    );

    assign list_full = cell_q[MAX_TASKS-1].valid;
    assign head_due  = cell_q[0].valid && (cell_q[0].delta == 16'd0);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                if ((req_reg.op == OP_ADD) && !list_full)
                begin
                    state_next = S_CONV;
                end
                else if ((req_reg.op == OP_DISPATCH) && head_due &&
                         (cell_q[0].period != 16'd0))
                begin
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (conv_done)
                begin
                    state_next = cell_shift[MAX_TASKS-1] ? S_DONE : S_WALK;
                end
            end
            S_WALK:
            begin
                if (cell_shift[MAX_TASKS-1])
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        tick           = 1'b0;
        conv_start     = 1'b0;
        conv_ms        = req_reg.delay_ms;
        tok0           = '{valid: 1'b0, ticks: conv_ticks};
        req_next       = req_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                req_next = in_data;
            end
            S_EXEC:
            begin
                res_next = '0;
                case (req_reg.op)
                    OP_ADD:
                    begin
                        if (!list_full)
                        begin
                            res_next.ok = 1'b1;
                            conv_start  = 1'b1;
                        end
                    end
                    OP_TICK:
                    begin
                        tick = 1'b1;
                    end
                    OP_DISPATCH:
                    begin
                        if (head_due)
                        begin
                            pop               = 1'b1;
                            res_next.ok       = 1'b1;
                            res_next.run_task = cell_q[0].task_id;
                            req_next.task_id  = cell_q[0].task_id;
                            req_next.period_ms = cell_q[0].period;
                            conv_ms           = cell_q[0].period;
                            conv_start        = (cell_q[0].period != 16'd0);
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            S_CONV:
            begin
                tok0.valid = conv_done;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            tps_reg       <= TPS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                tps_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the delta-list task scheduler core. A software copy of the
// task list predicts ok/run_task for every accepted request; results are
// checked in order. Directed requests cover empty-list, op 3, equal due
// times, periodic re-add, table full and rate extremes. Random phases then
// run under several tick rates, with random idling on both channels and one
// long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import dlts_pkg::*;

    localparam logic [1:0] OP_NONE   = 2'd3;
    localparam int         LONG_HOLD = 300;

    class schedule_predictor;
        logic [15:0] rate;
        logic [7:0]  slot_task   [MAX_TASKS];
        logic [15:0] slot_delta  [MAX_TASKS];
        logic [15:0] slot_period [MAX_TASKS];
        logic [3:0]  slot_link   [MAX_TASKS];
        bit          slot_busy   [MAX_TASKS];
        logic [3:0]  head;
        bit          nonempty;
        out_req_t    pending_results[$];
        int          mismatches;

        function new();
            rate = TPS_RESET;
            for (int i = 0; i < MAX_TASKS; i++)
                slot_busy[i] = 1'b0;
            head       = '0;
            nonempty   = 1'b0;
            mismatches = 0;
        endfunction

        function void set_rate(logic [15:0] v);
            rate = v;
        endfunction

        function bit place_task(logic [7:0] id, logic [15:0] delay, logic [15:0] period);
            int          s;
            logic [31:0] scaled;
            logic [15:0] ticks;
            logic [3:0]  cur;
            logic [3:0]  prev;
            bit          cur_ok;
            bit          have_prev;
            int          steps;
            s = -1;
            for (int i = MAX_TASKS - 1; i >= 0; i--)
                if (!slot_busy[i])
                    s = i;
            if (s < 0)
                return 1'b0;
            scaled = ({16'd0, delay} * {16'd0, rate}) / MS_PER_SECOND;
            ticks  = (scaled > 32'd65535) ? 16'hFFFF : scaled[15:0];
            cur       = head;
            cur_ok    = nonempty;
            prev      = '0;
            have_prev = 1'b0;
            steps     = 0;
            while (cur_ok && steps < MAX_TASKS && ticks >= slot_delta[cur])
            begin
                ticks     = ticks - slot_delta[cur];
                prev      = cur;
                have_prev = 1'b1;
                if (slot_link[cur] == cur)
                    cur_ok = 1'b0;
                else
                    cur = slot_link[cur];
                steps++;
            end
            slot_task[s]   = id;
            slot_period[s] = period;
            slot_busy[s]   = 1'b1;
            slot_link[s]   = cur_ok ? cur : 4'(s);
            if (have_prev)
                slot_link[prev] = 4'(s);
            else
            begin
                head     = 4'(s);
                nonempty = 1'b1;
            end
            if (cur_ok)
                slot_delta[cur] = slot_delta[cur] - ticks;
            slot_delta[s] = ticks;
            return 1'b1;
        endfunction

        function void note_request(in_req_t r);
            out_req_t    res;
            logic [3:0]  h;
            logic [7:0]  t;
            logic [15:0] p;
            res = '0;
            h   = head;
            case (r.op)
                OP_ADD:
                    res.ok = place_task(r.task_id, r.delay_ms, r.period_ms);
                OP_TICK:
                    if (nonempty && slot_delta[h] != 16'd0)
                        slot_delta[h] = slot_delta[h] - 16'd1;
                OP_DISPATCH:
                    if (nonempty && slot_delta[h] == 16'd0)
                    begin
                        t = slot_task[h];
                        p = slot_period[h];
                        if (slot_link[h] == h)
                            nonempty = 1'b0;
                        else
                            head = slot_link[h];
                        slot_busy[h] = 1'b0;
                        if (p != 16'd0)
                            void'(place_task(t, p, p));
                        res.ok       = 1'b1;
                        res.run_task = t;
                    end
                default:
                    ;
            endcase
            pending_results.push_back(res);
        endfunction

        function void check_result(out_req_t got);
            out_req_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result ok=%0d run_task=%0d",
                         $time, got.ok, got.run_task);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.ok !== want.ok)
            begin
                $display("%0t: ok mismatch, expected %0d actual %0d",
                         $time, want.ok, got.ok);
                mismatches++;
            end
            if (got.run_task !== want.run_task)
            begin
                $display("%0t: run_task mismatch, expected %0d actual %0d",
                         $time, want.run_task, got.run_task);
                mismatches++;
            end
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_we;
    logic     [15:0] cfg_wdata;
    logic     in_valid;
    logic     in_stall;
    in_req_t  in_data;
    logic     out_valid;
    logic     out_stall;
    out_req_t out_data;

    schedule_predictor model;
    bit gaps_on;
    bit hold_off;
    int send_calm;

    delta_list_task_scheduler_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #6_000_000;
        $display("delta_list_task_scheduler_core regression: fail");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            model.check_result(out_data);

    // result side: random stall bursts, quiet stretches, one long hold-off
    initial
    begin
        int quiet;
        out_stall = 1'b0;
        quiet     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
                hold_off = 1'b0;
            end
            else if (gaps_on && quiet == 0 && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                out_stall <= 1'b0;
                quiet = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : 0;
            end
            else if (quiet > 0)
                quiet--;
        end
    end

    // entered at a falling edge, returns at a falling edge
    task automatic send_request(in_req_t r);
        if (send_calm > 0)
            send_calm--;
        else if ($urandom_range(0, 29) == 0)
            send_calm = $urandom_range(10, 40);
        else if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        model.note_request(r);
        @(negedge clk);
    endtask

    task automatic write_rate(logic [15:0] v);
        in_valid <= 1'b0;
        while (model.pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        model.set_rate(v);
        @(negedge clk);
    endtask

    function automatic in_req_t make_req(logic [1:0] op, logic [7:0] id,
                                         logic [15:0] delay, logic [15:0] period);
        in_req_t r;
        r.op        = op;
        r.task_id   = id;
        r.delay_ms  = delay;
        r.period_ms = period;
        return r;
    endfunction

    function automatic in_req_t random_request(int delay_max, int wide_pct,
                                               int period_max, int period_wide_pct);
        in_req_t r;
        int      pick;
        r.task_id   = 8'($urandom);
        r.delay_ms  = 16'($urandom);
        r.period_ms = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30)
            r.op = OP_ADD;
        else if (pick < 65)
            r.op = OP_TICK;
        else if (pick < 95)
            r.op = OP_DISPATCH;
        else
            r.op = OP_NONE;
        if (r.op == OP_ADD)
        begin
            if ($urandom_range(0, 99) >= wide_pct)
                r.delay_ms = ($urandom_range(0, 3) == 0) ? 16'd0
                                                        : 16'($urandom_range(0, delay_max));
            pick = $urandom_range(0, 99);
            if (pick < 40)
                r.period_ms = 16'd0;
            else if (pick >= 40 + period_wide_pct)
                r.period_ms = 16'($urandom_range(0, period_max));
        end
        return r;
    endfunction

    task automatic run_phase(int count, int delay_max, int wide_pct,
                             int period_max, int period_wide_pct);
        in_req_t r;
        int      done;
        done = 0;
        while (done < count)
        begin
            r = random_request(delay_max, wide_pct, period_max, period_wide_pct);
            send_request(r);
            if (r.op != OP_NONE)
                done++;
        end
    endtask

    initial
    begin
        model     = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        gaps_on   = 1'b1;
        hold_off  = 1'b0;
        send_calm = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // rate extremes: slow rate, saturation, zero rate
        write_rate(16'd1);
        send_request(make_req(OP_ADD, 8'h00, 16'hFFFF, 16'hFFFF));
        write_rate(16'hFFFF);
        send_request(make_req(OP_ADD, 8'h3C, 16'd1001, 16'd0));
        write_rate(16'd0);
        send_request(make_req(OP_ADD, 8'hC3, 16'hFFFF, 16'd0));
        send_request(make_req(OP_DISPATCH, 8'h00, 16'd0, 16'd0));

        write_rate(TPS_RESET);
        send_request(make_req(OP_NONE, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_request(make_req(OP_ADD, 8'hFF, 16'd0, 16'd0));
        send_request(make_req(OP_TICK, 8'h00, 16'd0, 16'd0));
        send_request(make_req(OP_DISPATCH, 8'h00, 16'd0, 16'd0));
        send_request(make_req(OP_DISPATCH, 8'h00, 16'd0, 16'd0));
        // equal due times, head not yet due, periodic re-add
        send_request(make_req(OP_ADD, 8'hA5, 16'd3, 16'd2));
        send_request(make_req(OP_ADD, 8'h01, 16'd3, 16'd0));
        send_request(make_req(OP_DISPATCH, 8'h00, 16'd0, 16'd0));
        repeat (3) send_request(make_req(OP_TICK, 8'h00, 16'd0, 16'd0));
        send_request(make_req(OP_DISPATCH, 8'h00, 16'd0, 16'd0));
        send_request(make_req(OP_DISPATCH, 8'h00, 16'd0, 16'd0));
        // fill the table until adds are refused
        for (int i = 0; i < 15; i++)
            send_request(make_req(OP_ADD, 8'(8'h10 + i), 16'd0, 16'd0));

        write_rate(16'd1000);
        run_phase(250, 12, 0, 12, 0);
        write_rate(16'hFFFF);
        run_phase(200, 1, 0, 1, 0);
        write_rate(16'd0);
        hold_off = 1'b1;
        run_phase(230, 0, 100, 40, 0);
        write_rate(16'd1);
        run_phase(230, 2000, 50, 40, 30);
        write_rate(16'($urandom_range(2, 2000)));
        run_phase(230, 20, 2, 20, 2);
        gaps_on = 1'b0;
        write_rate(16'd1000);
        run_phase(230, 10, 0, 10, 0);

        in_valid <= 1'b0;
        while (model.pending_results.size() != 0)
            @(negedge clk);
        repeat (30) @(posedge clk);
        if (model.mismatches == 0 && model.pending_results.size() == 0)
            $display("delta_list_task_scheduler_core regression: pass");
        else
        begin
            if (model.pending_results.size() != 0)
                $display("%0t: %0d results never arrived",
                         $time, model.pending_results.size());
            $display("delta_list_task_scheduler_core regression: fail");
        end
        $finish;
    end
endmodule
